### hdl/pj128_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pj128_pkg: shared types, constants and round functions
// Holds the matrix and key-schedule constants, the control state type, the
// command/status bundles and the per-round cipher functions.
// ----------------------------------------------------------------------------
package pj128_pkg;

  localparam int PJ_ROUND_COUNT = 14;

  // Row-mixing matrices (first rows of the circulant matrices)
  localparam logic [31:0] MIX_ROW0 = 32'ha3861085;
  localparam logic [31:0] MIX_ROW1 = 32'h63417021;
  localparam logic [31:0] MIX_ROW2 = 32'h692cf280;
  localparam logic [31:0] MIX_ROW3 = 32'h48a54813;
  localparam logic [31:0] INV_ROW0 = 32'h2037a121;
  localparam logic [31:0] INV_ROW1 = 32'h108ff2a0;
  localparam logic [31:0] INV_ROW2 = 32'h9054d8c0;
  localparam logic [31:0] INV_ROW3 = 32'h3354b117;

  // Key schedule constants
  localparam logic [31:0] KS_MIX     = 32'hb881b9ca;
  localparam logic [31:0] KS_CONST0  = 32'h00000080;
  localparam logic [31:0] KS_CONST1  = 32'h00006a00;
  localparam logic [31:0] KS_CONST2  = 32'h003f0000;
  localparam logic [31:0] KS_CONST3  = 32'h24000000;
  localparam int          KS_ROT1    = 8;
  localparam int          KS_ROT2    = 15;
  localparam int          KS_ROT3    = 18;

  typedef logic [3:0][31:0] pj_block_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEYGEN,
    ST_RUN,
    ST_HOLD
  } pj_state_t;

  typedef struct packed {
    logic key_load;      // take a key word, restart the schedule
    logic key_step;      // write one round-key row, advance schedule
    logic in_load;       // capture an input beat
    logic run_step;      // advance the cipher state by one step
    logic decrypt;
    logic first;
    logic last;
    logic out_load;      // fill the output register
    logic out_from_hold; // take the output from the parked state
  } pj_cmd_t;

  typedef struct packed {
    logic out_free;
  } pj_status_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  // Multiply v by the circulant matrix whose first row is m.
  function automatic logic [31:0] circ_mul(input logic [31:0] m, input logic [31:0] v);
    logic [31:0] acc;
    acc = '0;
    for (int j = 0; j < 32; j++) begin
      acc ^= {32{v[j]}} & ror32(m, 31 - j);
    end
    return acc;
  endfunction

  function automatic pj_block_t enc_round(input pj_block_t s);
    logic [31:0] a, b, c, d;
    pj_block_t o;
    a = s[0]; b = s[1]; c = s[2]; d = s[3];
    a ^= d;
    d ^= a & b;
    a ^= b & c;
    b ^= c & d;
    c ^= a & d;
    c ^= b;
    b ^= a;
    d = ~d;
    o[0] = circ_mul(MIX_ROW0, a);
    o[1] = circ_mul(MIX_ROW1, b);
    o[2] = circ_mul(MIX_ROW2, d);
    o[3] = circ_mul(MIX_ROW3, c);
    return o;
  endfunction

  function automatic pj_block_t dec_round(input pj_block_t s);
    logic [31:0] a, b, c, d;
    pj_block_t o;
    a = circ_mul(INV_ROW0, s[0]);
    b = circ_mul(INV_ROW1, s[1]);
    d = circ_mul(INV_ROW2, s[2]);
    c = circ_mul(INV_ROW3, s[3]);
    d = ~d;
    b ^= a;
    c ^= b;
    c ^= a & d;
    b ^= c & d;
    a ^= b & c;
    d ^= a & b;
    a ^= d;
    o[0] = a; o[1] = b; o[2] = c; o[3] = d;
    return o;
  endfunction

endpackage

### hdl/pj128_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pj128_in_if: input block channel
// Valid/ready channel carrying one block and its opcode per beat.
// ----------------------------------------------------------------------------
interface pj128_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  logic        opcode;

  modport source (output valid, output block_hi, output block_lo, output opcode,
                  input ready);
  modport sink   (input valid, input block_hi, input block_lo, input opcode,
                  output ready);
endinterface

### hdl/pj128_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pj128_out_if: result block channel
// Valid/ready channel carrying one result block per beat.
// ----------------------------------------------------------------------------
interface pj128_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;

  modport source (output valid, output result_hi, output result_lo, input ready);
  modport sink   (input valid, input result_hi, input result_lo, output ready);
endinterface

### hdl/pj128_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pj128_ctrl: sequencer
// Runs the key schedule and the cipher rounds, issues round-key read
// addresses and datapath commands.
// ----------------------------------------------------------------------------
module pj128_ctrl
  import pj128_pkg::*;
#(
  parameter int ROUND_COUNT = PJ_ROUND_COUNT,
  localparam int SW = $clog2(ROUND_COUNT + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          in_valid,
  input  logic          in_opcode,
  output logic          in_ready,
  input  pj_status_t    status,
  output pj_cmd_t       cmd,
  output logic [SW-1:0] step,
  output logic [SW-1:0] rd_addr
);

  localparam logic [SW-1:0] LAST = SW'(ROUND_COUNT);

  pj_state_t     state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          op_r, op_nxt;
  logic          accept;
  logic [SW-1:0] next_idx;

  assign accept   = (state_r == ST_IDLE) && in_valid && !cfg_we;
  assign in_ready = (state_r == ST_IDLE) && !cfg_we;
  assign step     = step_r;
  assign next_idx = step_r + SW'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (cfg_we) begin
      state_nxt = ST_KEYGEN;
    end else begin
      unique case (state_r)
        ST_IDLE:   if (in_valid) state_nxt = ST_RUN;
        ST_KEYGEN: if (step_r == LAST) state_nxt = ST_IDLE;
        ST_RUN: begin
          if (step_r == LAST) state_nxt = status.out_free ? ST_IDLE : ST_HOLD;
        end
        ST_HOLD:   if (status.out_free) state_nxt = ST_IDLE;
        default:   state_nxt = ST_IDLE;
      endcase
    end
  end

  // Step counter and opcode
  always_comb begin
    step_nxt = step_r;
    op_nxt   = op_r;
    if (cfg_we || accept) begin
      step_nxt = '0;
    end else if ((state_r == ST_KEYGEN || state_r == ST_RUN) && step_r != LAST) begin
      step_nxt = next_idx;
    end
    if (accept) op_nxt = in_opcode;
  end

  // Round-key read address, issued for the next step ahead of its use
  always_comb begin
    if (accept) begin
      rd_addr = in_opcode ? LAST : '0;
    end else begin
      rd_addr = op_r ? (LAST - next_idx) : next_idx;
    end
  end

  // Commands
  always_comb begin
    cmd               = '0;
    cmd.key_load      = cfg_we;
    cmd.key_step      = (state_r == ST_KEYGEN) && !cfg_we;
    cmd.in_load       = accept;
    cmd.run_step      = (state_r == ST_RUN);
    cmd.decrypt       = op_r;
    cmd.first         = (step_r == '0);
    cmd.last          = (step_r == LAST);
    cmd.out_load      = status.out_free &&
                        (((state_r == ST_RUN) && step_r == LAST) || state_r == ST_HOLD);
    cmd.out_from_hold = (state_r == ST_HOLD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      op_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

### hdl/pj128_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pj128_dpath: cipher datapath
// Key words, key-schedule state, round-key memory, cipher state and the
// output register.
// ----------------------------------------------------------------------------
module pj128_dpath
  import pj128_pkg::*;
#(
  parameter int ROUND_COUNT = PJ_ROUND_COUNT,
  localparam int ROWS = ROUND_COUNT + 1,
  localparam int SW = $clog2(ROWS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pj_cmd_t       cmd,
  output pj_status_t    status,
  input  logic [SW-1:0] step,
  input  logic [SW-1:0] rd_addr,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic [63:0]   in_block_hi,
  input  logic [63:0]   in_block_lo,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   out_result_hi,
  output logic [63:0]   out_result_lo
);

  pj_block_t   key_r, key_nxt;
  pj_block_t   kg_r, kg_step;
  pj_block_t   rk_mem [ROWS];
  pj_block_t   rk_q;
  pj_block_t   s_r, s_res, s_key;
  pj_block_t   out_r;
  logic        out_valid_r;
  logic [31:0] kg_t;

  // Merge the incoming key word
  always_comb begin
    key_nxt            = key_r;
    key_nxt[cfg_index] = cfg_data;
  end

  // One key-schedule round
  always_comb begin
    kg_t       = kg_r[0] ^ kg_r[1] ^ kg_r[2] ^ kg_r[3];
    kg_step[0] = circ_mul(KS_MIX, kg_r[0] ^ kg_t) ^ KS_CONST0 ^ 32'(step);
    kg_step[1] = ror32(kg_r[1] ^ kg_t, KS_ROT1) ^ KS_CONST1;
    kg_step[2] = ror32(kg_r[2] ^ kg_t, KS_ROT2) ^ KS_CONST2;
    kg_step[3] = ror32(kg_r[3] ^ kg_t, KS_ROT3) ^ KS_CONST3;
  end

  // One cipher step
  always_comb begin
    s_key = s_r ^ rk_q;
    if (cmd.decrypt) begin
      s_res = cmd.first ? s_key : (dec_round(s_r) ^ rk_q);
    end else begin
      s_res = cmd.last ? s_key : enc_round(s_key);
    end
  end

  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.key_step) rk_mem[step] <= kg_r;
    rk_q <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.key_load) begin
      kg_r <= key_nxt;
    end else if (cmd.key_step) begin
      kg_r <= kg_step;
    end
    if (cmd.in_load) begin
      s_r <= {in_block_lo[31:0], in_block_lo[63:32], in_block_hi[31:0], in_block_hi[63:32]};
    end else if (cmd.run_step) begin
      s_r <= s_res;
    end
    if (cmd.out_load) out_r <= cmd.out_from_hold ? s_r : s_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.key_load) key_r <= key_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result_hi = {out_r[0], out_r[1]};
  assign out_result_lo = {out_r[2], out_r[3]};

endmodule

### hdl/pyjamask_128_block_cipher.sv
`timescale 1ns / 1ps
// A new block is accepted only in the idle state, once the previous result is in the
// output register. Rounds run one per cycle, paced by the single round unit and the
// one-row-per-cycle read of the round-key memory.
// Key write: the schedule then writes one round-key row per cycle; in_ch.ready stays low
// meanwhile. Reset clears control and key words;
// the round-key memory holds garbage until the first key write.
// ----------------------------------------------------------------------------
// pyjamask_128_block_cipher: Pyjamask-128 encrypt/decrypt core
// Round-iterated core with a stored key schedule; a sequencer drives a
// datapath holding the round unit, key memory and output register.
// ----------------------------------------------------------------------------
module pyjamask_128_block_cipher
  import pj128_pkg::*;
#(
  parameter int ROUND_COUNT = PJ_ROUND_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  pj128_in_if.sink    in_ch,
  pj128_out_if.source out_ch
);

  localparam int SW = $clog2(ROUND_COUNT + 1);

  pj_cmd_t       cmd;
  pj_status_t    status;
  logic [SW-1:0] step;
  logic [SW-1:0] rd_addr;

  // Sequencer: owns the state, the step count and the key-memory read address.
  pj128_ctrl #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .status    (status),
    .cmd       (cmd),
    .step      (step),
    .rd_addr   (rd_addr)
  );

  // Datapath: the output register lets a finished beat wait while the next
  // block is taken in.
  pj128_dpath #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .step          (step),
    .rd_addr       (rd_addr),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_block_hi   (in_ch.block_hi),
    .in_block_lo   (in_ch.block_lo),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_result_hi (out_ch.result_hi),
    .out_result_lo (out_ch.result_lo)
  );

endmodule
